// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Types and constants shared by the light tracker integral servo modules.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 3;
    localparam int MODE_W   = 2;
    localparam int SP_W     = 11;
    localparam int GAIN_W   = 8;
    localparam int NUM_W    = 20;   // best*ch + second*ch, channels up to 7
    localparam int DEN_W    = 17;
    localparam int POS_W    = 11;   // position never exceeds 7.0 in Q8
    localparam int FRAC_W   = 8;
    localparam int ERR_W    = 13;
    localparam int OUT_ERR_W = 12;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;
    localparam int INTEG_W  = 23;
    localparam int SUM_W    = INTEG_W + 2;
    localparam int DAC_W    = 12;
    localparam int FRAC_Q11 = 11;

    localparam int DIV_STEPS = POS_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DAC_W-1:0]   DAC_MAX     = 12'hFFF;
    localparam logic [INTEG_W-1:0] INTEG_RESET = INTEG_W'(2047 * 2048);
    localparam logic [INTEG_W-1:0] INTEG_MAX   = INTEG_W'(4095 * 2048);

    localparam logic [SP_W-1:0]   SETPOINT_RESET  = SP_W'(896);
    localparam logic [GAIN_W-1:0] GAIN_RESET      = GAIN_W'(1);
    localparam logic [SP_W-1:0]   THRESHOLD_RESET = SP_W'(64);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_SLEEP  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_SETPOINT  = 2'd0,
        REG_GAIN      = 2'd1,
        REG_THRESHOLD = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_direct;   // non-auto item, result without computation
        logic is_last;     // auto sample on the last channel
    } dp_status_t;

endpackage

// ===== sv/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_ctrl
// Sequencer for the servo: accepts items, steps the divider and loads results.
// ----------------------------------------------------------------------------
module lts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lts_pkg::dp_status_t status,
    output lts_pkg::dp_cmd_t    cmd
);
    import lts_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && aresetn;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    if (status.is_direct) begin
                        state_next = ST_LOAD;
                    end else if (status.is_last) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // The output register may be refilled in the cycle it is emptied.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lts_dp.sv =====
// ----------------------------------------------------------------------------
// lts_dp
// Datapath: brightness tracker, position divider, integrator, result registers.
// ----------------------------------------------------------------------------
module lts_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lts_pkg::dp_cmd_t                       cmd,
    output lts_pkg::dp_status_t                    status,
    input  logic [lts_pkg::MODE_W-1:0]             s_mode,
    input  logic [lts_pkg::CH_W-1:0]               s_channel,
    input  logic [lts_pkg::SAMPLE_W-1:0]           s_sample,
    input  logic [lts_pkg::SAMPLE_W-1:0]           s_manual_value,
    input  logic [lts_pkg::SP_W-1:0]               setpoint_q8,
    input  logic [lts_pkg::GAIN_W-1:0]             gain_eighths,
    input  logic [lts_pkg::SP_W-1:0]               settle_threshold_q8,
    output logic [lts_pkg::DAC_W-1:0]              m_dac_code,
    output logic signed [lts_pkg::OUT_ERR_W-1:0]   m_error_q8,
    output logic                                   m_settled
);
    import lts_pkg::*;

    logic [SAMPLE_W-1:0] best_value_reg, second_value_reg;
    logic [CH_W-1:0]     best_channel_reg, second_channel_reg;
    logic                second_seen_reg;
    logic [INTEG_W-1:0]  integ_reg;

    logic [DEN_W-1:0]    den_reg;
    logic                den_zero_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [POS_W-1:0]    low_reg;
    logic [POS_W-1:0]    quo_reg;

    logic [DAC_W-1:0]     pend_dac_reg;
    logic [OUT_ERR_W-1:0] pend_err_reg;
    logic                 pend_settled_reg;
    logic [DAC_W-1:0]     out_dac_reg;
    logic [OUT_ERR_W-1:0] out_err_reg;
    logic                 out_settled_reg;

    logic                track_en;
    logic [NUM_W-1:0]    num_next;
    logic [DEN_W-1:0]    den_next;
    logic [DEN_W:0]      shifted;
    logic [DEN_W:0]      trial;
    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic [INTEG_W-1:0]       integ_next;
    logic [DAC_W-1:0]         manual_dac;

    assign track_en         = (s_mode == MODE_AUTO) && (int'(s_channel) < NUM_SENSORS);
    assign status.is_direct = (s_mode != MODE_AUTO);
    assign status.is_last   = (s_mode == MODE_AUTO) && (int'(s_channel) == NUM_SENSORS - 1);

    assign manual_dac = (s_manual_value > SAMPLE_W'(DAC_MAX)) ? DAC_MAX
                                                              : s_manual_value[DAC_W-1:0];

    // Tracker: keeps the two brightest channels of the current scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_value_reg     <= '0;
            best_channel_reg   <= '0;
            second_value_reg   <= '0;
            second_channel_reg <= '0;
            second_seen_reg    <= 1'b0;
        end else if (cmd.accept && track_en) begin
            if (s_channel == '0) begin
                best_value_reg   <= s_sample;
                best_channel_reg <= '0;
                second_seen_reg  <= 1'b0;
            end else if (s_sample > best_value_reg) begin
                second_value_reg   <= best_value_reg;
                second_channel_reg <= best_channel_reg;
                second_seen_reg    <= 1'b1;
                best_value_reg     <= s_sample;
                best_channel_reg   <= s_channel;
            end else if (!second_seen_reg || (s_sample > second_value_reg)) begin
                second_value_reg   <= s_sample;
                second_channel_reg <= s_channel;
                second_seen_reg    <= 1'b1;
            end
        end
    end

    assign num_next = NUM_W'(best_value_reg) * NUM_W'(best_channel_reg)
                    + NUM_W'(second_value_reg) * NUM_W'(second_channel_reg);
    assign den_next = DEN_W'(best_value_reg) + DEN_W'(second_value_reg);

    // Restoring divide of num*256 by den. The quotient is below 2^POS_W, so the
    // top dividend bits already sit below the divisor and only POS_W steps run.
    assign shifted = {rem_reg, low_reg[POS_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            den_reg      <= den_next;
            den_zero_reg <= (den_next == '0);
            rem_reg      <= num_next[NUM_W-1:NUM_W-DEN_W];
            low_reg      <= {num_next[NUM_W-DEN_W-1:0], {FRAC_W{1'b0}}};
            quo_reg      <= '0;
        end else if (cmd.div_step) begin
            low_reg <= {low_reg[POS_W-2:0], 1'b0};
            if (!trial[DEN_W]) begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], 1'b0};
            end
        end
    end

    assign err  = den_zero_reg ? '0
                : $signed({2'b00, setpoint_q8}) - $signed({2'b00, quo_reg});
    assign prod = err * $signed({1'b0, gain_eighths});
    assign sum  = $signed({2'b00, integ_reg})
                + $signed({{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod});

    always_comb begin
        if (sum < 0) begin
            integ_next = '0;
        end else if (sum > $signed({2'b00, INTEG_MAX})) begin
            integ_next = INTEG_MAX;
        end else begin
            integ_next = sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= INTEG_RESET;
        end else if (cmd.update) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && status.is_direct) begin
            pend_dac_reg     <= (s_mode == MODE_MANUAL) ? manual_dac : '0;
            pend_err_reg     <= '0;
            pend_settled_reg <= 1'b0;
        end else if (cmd.update) begin
            pend_dac_reg     <= integ_next[INTEG_W-1:FRAC_Q11];
            pend_err_reg     <= err[OUT_ERR_W-1:0];
            pend_settled_reg <= (err < $signed({2'b00, settle_threshold_q8}));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_dac_reg     <= pend_dac_reg;
            out_err_reg     <= pend_err_reg;
            out_settled_reg <= pend_settled_reg;
        end
    end

    assign m_dac_code = out_dac_reg;
    assign m_error_q8 = $signed(out_err_reg);
    assign m_settled  = out_settled_reg;

endmodule

// ===== sv/light_tracker_integral_servo.sv =====
// ----------------------------------------------------------------------------
// light_tracker_integral_servo
// Light-seeking servo: tracks the two brightest sensors, integrates the error.
// ----------------------------------------------------------------------------
// Input items arrive on s_valid/s_ready with mode, channel, sample and
// manual_value. Results leave on m_valid/m_ready with dac_code, error_q8 and
// settled. Settings are written through the APB port; pready is always high.
// An auto sample on a channel other than the last one only updates the
// brightness tracker: it gives no result and leaves the block idle, so
// these samples stream at one item per cycle. The last-channel sample
// runs a multiply step, a restoring divide and an integrator update, then
// waits to load its result into the output register; the next item is
// taken once the result is loaded. Manual, sleep and unused-mode items go
// straight to the load step.
// A finished result sits in an output register; while the receiver stalls,
// one further result is computed and held, and input then waits.
// Synchronous reset clears the tracker, loads the integrator with mid-scale,
// restores the register defaults and drops m_valid.
// ----------------------------------------------------------------------------
module light_tracker_integral_servo (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lts_pkg::MODE_W-1:0]            s_mode,
    input  logic [lts_pkg::CH_W-1:0]              s_channel,
    input  logic [lts_pkg::SAMPLE_W-1:0]          s_sample,
    input  logic [lts_pkg::SAMPLE_W-1:0]          s_manual_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lts_pkg::DAC_W-1:0]             m_dac_code,
    output logic signed [lts_pkg::OUT_ERR_W-1:0]  m_error_q8,
    output logic                                  m_settled,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lts_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [lts_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [lts_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import lts_pkg::*;

    logic [SP_W-1:0]   setpoint_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [SP_W-1:0]   threshold_reg;
    reg_idx_t          reg_idx;
    logic              wr_en;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= SETPOINT_RESET;
            gain_reg      <= GAIN_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SETPOINT:  setpoint_reg  <= pwdata[SP_W-1:0];
                REG_GAIN:      gain_reg      <= pwdata[GAIN_W-1:0];
                REG_THRESHOLD: threshold_reg <= pwdata[SP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SETPOINT:  prdata = APB_DATA_W'(setpoint_reg);
            REG_GAIN:      prdata = APB_DATA_W'(gain_reg);
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    lts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lts_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_mode              (s_mode),
        .s_channel           (s_channel),
        .s_sample            (s_sample),
        .s_manual_value      (s_manual_value),
        .setpoint_q8         (setpoint_reg),
        .gain_eighths        (gain_reg),
        .settle_threshold_q8 (threshold_reg),
        .m_dac_code          (m_dac_code),
        .m_error_q8          (m_error_q8),
        .m_settled           (m_settled)
    );

endmodule

// ===== sv/lts_checker.sv =====
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks for the light tracker integral servo, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lts_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [lts_pkg::MODE_W-1:0]            s_mode,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [lts_pkg::DAC_W-1:0]             m_dac_code,
    input logic signed [lts_pkg::OUT_ERR_W-1:0]  m_error_q8,
    input logic                                  m_settled
);
    import lts_pkg::*;

    // A stalled result keeps its item intact.
    `ASSERT_RST(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_dac_code) && $stable(m_error_q8) && $stable(m_settled), "result changed while stalled")

    `ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "m_valid not cleared by reset")

    // A manual, sleep or unused-mode item occupies the block until its result is loaded.
    `ASSERT_RST(a_direct_busy, aclk, aresetn, s_valid && s_ready && (s_mode != MODE_AUTO) |=> !s_ready, "input still ready after manual or sleep item")

    // A new result only appears when input was held off in the previous cycle.
    `ASSERT_RST(a_load_gap, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result loaded while input was open")

endmodule

bind light_tracker_integral_servo lts_checker u_lts_checker (.*);

// ===== dv/light_tracker_integral_servo_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_tracker_integral_servo_tb
// Self-checking testbench for the light tracker integral servo.
// ----------------------------------------------------------------------------
// A queue of sensor items feeds a clocked driver. Each accepted item runs
// through a behavioral model of the brightness tracker, the Q8 position
// divide and the saturating Q11 integrator. A clocked monitor compares every
// servo result with the oldest predicted one. Phases vary the settings over
// the APB port and the amount of idling on both channels.
// ----------------------------------------------------------------------------
module light_tracker_integral_servo_tb;
    import lts_pkg::*;

    localparam int LAST_CH     = NUM_SENSORS - 1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_WAIT = 40;    // covers the last-channel path
    localparam int LONG_STALL  = 300;
    localparam longint INTEG_TOP = 64'd4095 * 64'd2048;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] manual_value;
    } sensor_item_t;

    typedef struct packed {
        logic [DAC_W-1:0]            dac_code;
        logic signed [OUT_ERR_W-1:0] error_q8;
        logic                        settled;
    } servo_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode = '0;
    logic [CH_W-1:0]       s_channel = '0;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic [SAMPLE_W-1:0]   s_manual_value = '0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [DAC_W-1:0]            m_dac_code;
    logic signed [OUT_ERR_W-1:0] m_error_q8;
    logic                        m_settled;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    light_tracker_integral_servo u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .s_manual_value(s_manual_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dac_code    (m_dac_code),
        .m_error_q8    (m_error_q8),
        .m_settled     (m_settled),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sensor_item_t  sensor_q[$];
    servo_result_t servo_expect_q[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic recv_block = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    // Shadow settings and tracker state of the servo.
    logic [SP_W-1:0]     cfg_setpoint  = SETPOINT_RESET;
    logic [GAIN_W-1:0]   cfg_gain      = GAIN_RESET;
    logic [SP_W-1:0]     cfg_threshold = THRESHOLD_RESET;
    logic [SAMPLE_W-1:0] trk_best_val = '0;
    logic [CH_W-1:0]     trk_best_ch = '0;
    logic [SAMPLE_W-1:0] trk_second_val = '0;
    logic [CH_W-1:0]     trk_second_ch = '0;
    logic                trk_second_seen = 1'b0;
    longint              integ_q11 = 64'd2047 * 64'd2048;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Predicts direct results; updates tracker and last-channel integrator.
    task automatic predict_servo(input sensor_item_t it);
        servo_result_t r;
        longint num, den, err;
        r = '0;
        if (it.mode == MODE_MANUAL) begin
            r.dac_code = (it.manual_value > DAC_MAX) ? DAC_MAX : it.manual_value[DAC_W-1:0];
            servo_expect_q.push_back(r);
        end else if (it.mode != MODE_AUTO) begin
            servo_expect_q.push_back(r);
        end else begin
            if (it.channel == 0) begin
                trk_best_val    = it.sample;
                trk_best_ch     = '0;
                trk_second_seen = 1'b0;
            end else if (it.sample > trk_best_val) begin
                trk_second_val  = trk_best_val;
                trk_second_ch   = trk_best_ch;
                trk_second_seen = 1'b1;
                trk_best_val    = it.sample;
                trk_best_ch     = it.channel;
            end else if (!trk_second_seen || it.sample > trk_second_val) begin
                trk_second_val  = it.sample;
                trk_second_ch   = it.channel;
                trk_second_seen = 1'b1;
            end
            if (it.channel == LAST_CH) begin
                den = longint'(trk_best_val) + longint'(trk_second_val);
                num = longint'(trk_best_val) * trk_best_ch
                    + longint'(trk_second_val) * trk_second_ch;
                err = 0;
                if (den != 0)
                    err = longint'(cfg_setpoint) - (num * 256) / den;
                integ_q11 += err * longint'(cfg_gain);
                if (integ_q11 > INTEG_TOP)
                    integ_q11 = INTEG_TOP;
                else if (integ_q11 < 0)
                    integ_q11 = 0;
                r.dac_code = DAC_W'(integ_q11 / 2048);
                r.error_q8 = OUT_ERR_W'(err);
                r.settled  = (err < longint'(cfg_threshold));
                servo_expect_q.push_back(r);
            end
        end
    endtask

    // Driver: a new item may be presented once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_servo({s_mode, s_channel, s_sample, s_manual_value});
            if (!s_valid || s_ready) begin
                if (sensor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sensor_item_t it;
                    it = sensor_q.pop_front();
                    s_valid        <= 1'b1;
                    s_mode         <= it.mode;
                    s_channel      <= it.channel;
                    s_sample       <= it.sample;
                    s_manual_value <= it.manual_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (servo_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, dac_code", m_dac_code, -1);
                end else begin
                    servo_result_t want;
                    want = servo_expect_q.pop_front();
                    if (m_dac_code !== want.dac_code)
                        report_mismatch("dac_code", m_dac_code, want.dac_code);
                    if (m_error_q8 !== want.error_q8)
                        report_mismatch("error_q8", m_error_q8, want.error_q8);
                    if (m_settled !== want.settled)
                        report_mismatch("settled", m_settled, want.settled);
                end
            end
            m_ready <= !recv_block && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SETPOINT:  cfg_setpoint  = value[SP_W-1:0];
            REG_GAIN:      cfg_gain      = value[GAIN_W-1:0];
            REG_THRESHOLD: cfg_threshold = value[SP_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every item is taken and every result is back, then lets
    // the block settle.
    task automatic drain();
        do @(negedge aclk);
        while (sensor_q.size() != 0 || s_valid || servo_expect_q.size() != 0);
        repeat (SETTLE_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic start_phase(input int setpoint, input int gain, input int threshold,
                               input int send_pct, input int recv_pct);
        apb_write(REG_SETPOINT, setpoint);
        apb_write(REG_GAIN, gain);
        apb_write(REG_THRESHOLD, threshold);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic sensor_item_t make_item(input logic [MODE_W-1:0] mode, input int ch,
                                               input int sample, input int manual);
        sensor_item_t it;
        it.mode         = mode;
        it.channel      = CH_W'(ch);
        it.sample       = SAMPLE_W'(sample);
        it.manual_value = SAMPLE_W'(manual);
        return it;
    endfunction

    function automatic int rand_manual();
        return $urandom_range(1) ? $urandom_range(65535) : $urandom_range(4095);
    endfunction

    // One scan over a run of channels; the sample pattern decides ties,
    // zero brightness and full scale.
    task automatic push_scan(input int first_ch, input int last_ch);
        int pattern, common, hot, ch, v;
        pattern = $urandom_range(4);
        common  = $urandom_range(65535);
        hot     = $urandom_range(LAST_CH);
        for (ch = first_ch; ch <= last_ch; ch++) begin
            case (pattern)
                0: v = $urandom_range(65535);
                1: v = $urandom_range(3);
                2: v = common;
                3: v = (ch == hot) ? $urandom_range(65535) : 0;
                default: v = $urandom_range(1) ? 65535 : $urandom_range(65535);
            endcase
            sensor_q.push_back(make_item(MODE_AUTO, ch, v, rand_manual()));
        end
    endtask

    // Mostly whole scans, some broken scans, direct-mode items and noise.
    task automatic push_random(input int count);
        int queued, pick, first_ch;
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                push_scan(0, LAST_CH);
                queued += NUM_SENSORS;
            end else if (pick < 80) begin
                first_ch = $urandom_range(LAST_CH);
                push_scan(first_ch, $urandom_range(LAST_CH, first_ch));
                queued += 3;
            end else if (pick < 90) begin
                case ($urandom_range(2))
                    0: sensor_q.push_back(make_item(MODE_MANUAL, $urandom_range(LAST_CH),
                                                    $urandom_range(65535), rand_manual()));
                    1: sensor_q.push_back(make_item(MODE_SLEEP, $urandom_range(LAST_CH),
                                                    $urandom_range(65535), rand_manual()));
                    default: sensor_q.push_back(make_item(MODE_UNUSED,
                                                    $urandom_range(LAST_CH),
                                                    $urandom_range(65535), rand_manual()));
                endcase
                queued++;
            end else begin
                sensor_q.push_back(make_item(MODE_W'($urandom_range(3)),
                                             $urandom_range(LAST_CH),
                                             $urandom_range(65535), $urandom_range(65535)));
                queued++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A scan that skips channel 0 so the reset entry stands in, with a
        // tie at full scale between channels 2 and 3.
        sensor_q.push_back(make_item(MODE_AUTO, 1, 100, 0));
        sensor_q.push_back(make_item(MODE_AUTO, 2, 65535, 65535));
        sensor_q.push_back(make_item(MODE_AUTO, 3, 65535, 0));
        sensor_q.push_back(make_item(MODE_AUTO, 4, 0, 0));
        sensor_q.push_back(make_item(MODE_AUTO, 5, 100, 0));
        sensor_q.push_back(make_item(MODE_AUTO, 6, 200, 0));
        sensor_q.push_back(make_item(MODE_AUTO, 7, 50, 0));
        // All-dark scan gives a zero denominator.
        for (int ch = 0; ch <= LAST_CH; ch++)
            sensor_q.push_back(make_item(MODE_AUTO, ch, 0, 0));
        sensor_q.push_back(make_item(MODE_MANUAL, 0, 0, 0));
        sensor_q.push_back(make_item(MODE_MANUAL, 7, 65535, 4095));
        sensor_q.push_back(make_item(MODE_MANUAL, 0, 0, 4096));
        sensor_q.push_back(make_item(MODE_MANUAL, 0, 0, 65535));
        sensor_q.push_back(make_item(MODE_SLEEP, 7, 65535, 65535));
        sensor_q.push_back(make_item(MODE_UNUSED, 0, 0, 1234));
        drain();

        // Lowest setpoint at full gain drives the integrator to zero. The
        // receiver holds off while the sender keeps offering items.
        start_phase(0, 255, 0, 0, 0);
        push_random(60);
        @(posedge aclk);
        recv_block <= 1'b1;
        repeat (LONG_STALL) @(posedge aclk);
        recv_block <= 1'b0;
        drain();
        push_random(40);
        drain();

        start_phase(1792, 255, 1792, 79, 0);
        push_random(100);
        drain();

        start_phase($urandom_range(1792), 0, $urandom_range(1792), 0, 79);
        push_random(100);
        drain();

        start_phase(SETPOINT_RESET, GAIN_RESET, THRESHOLD_RESET, 35, 35);
        push_random(100);
        drain();

        start_phase($urandom_range(1792), $urandom_range(255), $urandom_range(1792), 35, 0);
        push_random(100);
        drain();

        if (mismatch_count == 0 && servo_expect_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
